>>> rtl/core/closed_spline_position_evaluator_defines.svh
// Assertion macros used by the checker file of the spline evaluator.
`ifndef CLOSED_SPLINE_POSITION_EVALUATOR_DEFINES_SVH
`define CLOSED_SPLINE_POSITION_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define CSP_IMPLY(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("spline evaluator assertion failed");

// next-cycle implication
`define CSP_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("spline evaluator assertion failed");

`endif

>>> rtl/core/csp_pkg.sv
// Shared types and constants of the spline evaluator.
package csp_pkg;
   localparam int COORD_W  = 32;
   localparam int TIME_W   = 32;
   localparam int PER_W    = 24;
   localparam int NUM_W    = 7;
   localparam int IDX_W    = 6;
   localparam int COEF_W   = 40;
   localparam int QDEPTH   = 4;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   localparam logic CSR_NUM_POINTS = 1'b0;
   localparam logic CSR_PERIOD     = 1'b1;

   typedef struct packed {
      logic [NUM_W-1:0] num_points;
      logic [PER_W-1:0] period_ms;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic [3*COORD_W-1:0] pt;   // {z, y, x}
   } wr_type;
endpackage

>>> rtl/core/csp_fifo.sv
// Small item queue between the front and back parts.
module csp_fifo import csp_pkg::*; #(
   parameter int DEPTH = 4,
   parameter int W     = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         full,
   output logic         empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + AW'(1);
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + AW'(1);
      end
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule

>>> rtl/core/csp_front.sv
// Front part: accepts items, holds config, issues point writes, queues evaluations.
module csp_front import csp_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int CNT_W      = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,
   input  logic          req_tuser,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [23:0]   csr_wdata,
   output cfg_type       cfg,
   output wr_type        wr,
   output logic          q_push,
   output logic [TIME_W-1:0] q_data,
   input  logic          q_full,
   input  logic          rd_take
);
   logic                 valid_ff;
   logic                 func_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [3*COORD_W-1:0] pt_ff;
   logic [TIME_W-1:0]    el_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_W-1:0]     np_ff;
   logic [PER_W-1:0]     per_ff;
   logic                 wr_go, done;

   // a write waits until every earlier evaluation has read the table
   assign wr_go  = valid_ff && (func_ff == FUNC_WRITE) && (cnt_ff == '0);
   assign q_push = valid_ff && (func_ff == FUNC_EVAL) && !q_full;
   assign done   = wr_go || q_push;
   assign req_tready = !valid_ff || done;
   assign q_data = el_ff;

   assign wr.en  = wr_go && (32'(idx_ff) < 32'(MAX_POINTS));
   assign wr.idx = idx_ff;
   assign wr.pt  = pt_ff;

   assign cfg.num_points = np_ff;
   assign cfg.period_ms  = per_ff;

   assign cnt_in = cnt_ff + CNT_W'(q_push) - CNT_W'(rd_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         np_ff    <= NUM_W'(4);
         per_ff   <= PER_W'(1000);
      end else begin
         cnt_ff <= cnt_in;
         if (req_tready) begin
            valid_ff <= req_tvalid;
         end
         if (csr_we) begin
            if (csr_index == CSR_NUM_POINTS) begin
               np_ff <= csr_wdata[NUM_W-1:0];
            end else begin
               per_ff <= csr_wdata[PER_W-1:0];
            end
         end
      end
      if (req_tready && req_tvalid) begin
         func_ff <= req_tuser;
         idx_ff  <= req_tdata[5:0];
         pt_ff   <= req_tdata[101:6];
         el_ff   <= req_tdata[133:102];
      end
   end
endmodule

>>> rtl/core/csp_back.sv
// Back part: phase divider, table lookup and Catmull-Rom cubic pipeline.
module csp_back import csp_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  wr_type            wr,
   input  logic              q_empty,
   input  logic [TIME_W-1:0] q_data,
   output logic              q_pop,
   output logic              rd_take,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [95:0]       rsp_tdata
);
   localparam int AW  = $clog2(MAX_POINTS);
   localparam int NW  = $clog2(MAX_POINTS + 1);
   localparam int QB  = AW + FRAC_BITS;
   localparam int PHW = PER_W + NW;
   localparam int MW  = COEF_W + FRAC_BITS + 1;
   localparam logic signed [MW-1:0]     HALF = MW'(1) << (FRAC_BITS - 1);
   localparam logic signed [COEF_W-1:0] SMAX = COEF_W'(64'sh7FFF_FFFF);
   localparam logic signed [COEF_W-1:0] SMIN = -COEF_W'(64'sh8000_0000);

   logic adv;
   logic [NW-1:0]    n_eff;
   logic [PER_W-1:0] per_eff;

   // loop size and period, clamped
   always_comb begin
      if (cfg.num_points == '0) begin
         n_eff = NW'(1);
      end else if (32'(cfg.num_points) > 32'(MAX_POINTS)) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = NW'(cfg.num_points);
      end
      per_eff = (cfg.period_ms == '0) ? PER_W'(1) : cfg.period_ms;
   end

   assign adv   = !rsp_tvalid || rsp_tready;
   assign q_pop = adv && !q_empty;

   // ---- elapsed mod period, one bit per stage
   logic              md_v_ff [33];
   logic [PER_W-1:0]  md_r_ff [33];
   logic [PER_W-1:0]  md_r_in [33];
   logic [TIME_W-1:0] md_e_ff [33];

   always_comb begin
      logic [PER_W:0] r2;
      md_r_in[0] = '0;
      for (int k = 0; k < 32; k++) begin
         r2 = {md_r_ff[k], md_e_ff[k][31-k]};
         if (r2 >= {1'b0, per_eff}) begin
            r2 = r2 - {1'b0, per_eff};
         end
         md_r_in[k+1] = r2[PER_W-1:0];
      end
   end

   // ---- phase = tm * n
   logic           ph_v_ff;
   logic [PHW-1:0] ph_ff;

   // ---- (phase << FRAC_BITS) / period, one quotient bit per stage
   logic           dv_v_ff [QB+1];
   logic [PER_W-1:0] dv_r_ff [QB+1];
   logic [PER_W-1:0] dv_r_in [QB+1];
   logic [QB-1:0]  dv_q_ff [QB+1];
   logic [QB-1:0]  dv_q_in [QB+1];
   logic [QB-1:0]  dv_d_ff [QB+1];

   always_comb begin
      logic [PER_W:0] r2;
      logic qb;
      // phase < n * period, so the top bits already sit below the period
      dv_r_in[0] = PER_W'(ph_ff >> AW);
      dv_q_in[0] = '0;
      for (int j = 0; j < QB; j++) begin
         r2 = {dv_r_ff[j], dv_d_ff[j][QB-1-j]};
         qb = (r2 >= {1'b0, per_eff});
         if (qb) begin
            r2 = r2 - {1'b0, per_eff};
         end
         dv_r_in[j+1] = r2[PER_W-1:0];
         dv_q_in[j+1] = {dv_q_ff[j][QB-2:0], qb};
      end
   end

   // ---- neighbor indices with wraparound
   logic [AW-1:0] seg;
   logic [NW-1:0] s_n, i0, i2, i3;
   logic          ix_v_ff;
   logic [AW-1:0] ix_ff [4];
   logic [FRAC_BITS-1:0] ix_t_ff;

   always_comb begin
      seg = dv_q_ff[QB][QB-1:FRAC_BITS];
      s_n = NW'(seg);
      i0  = (s_n == '0) ? n_eff - NW'(1) : s_n - NW'(1);
      i2  = (s_n + NW'(1) == n_eff) ? '0 : s_n + NW'(1);
      i3  = (i2 + NW'(1) == n_eff) ? '0 : i2 + NW'(1);
   end

   assign rd_take = ix_v_ff && adv;

   // ---- point table, one copy per read port
   logic [3*COORD_W-1:0] mem [4][MAX_POINTS];
   logic [3*COORD_W-1:0] rd_ff [4];
   logic                 rd_v_ff;
   logic [FRAC_BITS-1:0] rd_t_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int k = 0; k < 4; k++) begin
            mem[k][AW'(wr.idx)] <= wr.pt;
         end
      end
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            rd_ff[k] <= mem[k][ix_ff[k]];
         end
      end
   end

   // ---- cubic per axis
   logic signed [COEF_W-1:0] cf_a_ff [3], cf_b_ff [3], cf_c_ff [3], cf_d_ff [3];
   logic signed [COEF_W-1:0] cf_a_in [3], cf_b_in [3], cf_c_in [3], cf_d_in [3];
   logic signed [COEF_W-1:0] b1_ff [3], c1_ff [3], d1_ff [3];
   logic signed [COEF_W-1:0] c2_ff [3], d2_ff [3], c3_ff [3], d3_ff [3];
   logic signed [COEF_W-1:0] d4_ff [3], d5_ff [3];
   logic signed [COEF_W-1:0] h1_ff [3], h2_ff [3], h3_ff [3];
   logic signed [MW-1:0]     m1_ff [3], m2_ff [3], m3_ff [3];
   logic signed [COEF_W-1:0] y_in  [3];
   logic [COORD_W-1:0]       out_in [3];
   logic signed [FRAC_BITS:0] t_cf_ff, t_m1_ff, t_a1_ff, t_m2_ff, t_a2_ff;
   logic cf_v_ff, m1_v_ff, a1_v_ff, m2_v_ff, a2_v_ff, m3_v_ff, a3_v_ff, out_v_ff;
   logic [95:0] out_ff;

   always_comb begin
      logic signed [COEF_W-1:0] p0, p1, p2, p3;
      for (int ax = 0; ax < 3; ax++) begin
         p0 = COEF_W'($signed(rd_ff[0][32*ax +: 32]));
         p1 = COEF_W'($signed(rd_ff[1][32*ax +: 32]));
         p2 = COEF_W'($signed(rd_ff[2][32*ax +: 32]));
         p3 = COEF_W'($signed(rd_ff[3][32*ax +: 32]));
         cf_a_in[ax] = -p0 + 3 * p1 - 3 * p2 + p3;
         cf_b_in[ax] = 2 * p0 - 5 * p1 + 4 * p2 - p3;
         cf_c_in[ax] = p2 - p0;
         cf_d_in[ax] = 2 * p1;
         // halve, then clamp to 32 bits
         y_in[ax] = (h3_ff[ax] + COEF_W'(1)) >>> 1;
         if (y_in[ax] > SMAX) begin
            out_in[ax] = 32'h7FFF_FFFF;
         end else if (y_in[ax] < SMIN) begin
            out_in[ax] = 32'h8000_0000;
         end else begin
            out_in[ax] = y_in[ax][COORD_W-1:0];
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 33; k++) begin
            md_v_ff[k] <= 1'b0;
         end
         for (int j = 0; j <= QB; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
         ph_v_ff  <= 1'b0;
         ix_v_ff  <= 1'b0;
         rd_v_ff  <= 1'b0;
         cf_v_ff  <= 1'b0;
         m1_v_ff  <= 1'b0;
         a1_v_ff  <= 1'b0;
         m2_v_ff  <= 1'b0;
         a2_v_ff  <= 1'b0;
         m3_v_ff  <= 1'b0;
         a3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         md_v_ff[0] <= q_pop;
         for (int k = 1; k < 33; k++) begin
            md_v_ff[k] <= md_v_ff[k-1];
         end
         ph_v_ff    <= md_v_ff[32];
         dv_v_ff[0] <= ph_v_ff;
         for (int j = 1; j <= QB; j++) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
         ix_v_ff  <= dv_v_ff[QB];
         rd_v_ff  <= ix_v_ff;
         cf_v_ff  <= rd_v_ff;
         m1_v_ff  <= cf_v_ff;
         a1_v_ff  <= m1_v_ff;
         m2_v_ff  <= a1_v_ff;
         a2_v_ff  <= m2_v_ff;
         m3_v_ff  <= a2_v_ff;
         a3_v_ff  <= m3_v_ff;
         out_v_ff <= a3_v_ff;
      end
      if (adv) begin
         md_r_ff[0] <= md_r_in[0];
         md_e_ff[0] <= q_data;
         for (int k = 1; k < 33; k++) begin
            md_r_ff[k] <= md_r_in[k];
            md_e_ff[k] <= md_e_ff[k-1];
         end
         ph_ff <= PHW'(md_r_ff[32]) * PHW'(n_eff);
         dv_r_ff[0] <= dv_r_in[0];
         dv_q_ff[0] <= dv_q_in[0];
         dv_d_ff[0] <= {ph_ff[AW-1:0], {FRAC_BITS{1'b0}}};
         for (int j = 1; j <= QB; j++) begin
            dv_r_ff[j] <= dv_r_in[j];
            dv_q_ff[j] <= dv_q_in[j];
            dv_d_ff[j] <= dv_d_ff[j-1];
         end
         ix_ff[0] <= AW'(i0);
         ix_ff[1] <= seg;
         ix_ff[2] <= AW'(i2);
         ix_ff[3] <= AW'(i3);
         ix_t_ff  <= dv_q_ff[QB][FRAC_BITS-1:0];
         rd_t_ff  <= ix_t_ff;
         t_cf_ff  <= $signed({1'b0, rd_t_ff});
         t_m1_ff  <= t_cf_ff;
         t_a1_ff  <= t_m1_ff;
         t_m2_ff  <= t_a1_ff;
         t_a2_ff  <= t_m2_ff;
         for (int ax = 0; ax < 3; ax++) begin
            cf_a_ff[ax] <= cf_a_in[ax];
            cf_b_ff[ax] <= cf_b_in[ax];
            cf_c_ff[ax] <= cf_c_in[ax];
            cf_d_ff[ax] <= cf_d_in[ax];
            m1_ff[ax]   <= MW'(cf_a_ff[ax]) * MW'(t_cf_ff);
            b1_ff[ax]   <= cf_b_ff[ax];
            c1_ff[ax]   <= cf_c_ff[ax];
            d1_ff[ax]   <= cf_d_ff[ax];
            h1_ff[ax]   <= COEF_W'((m1_ff[ax] + HALF) >>> FRAC_BITS) + b1_ff[ax];
            c2_ff[ax]   <= c1_ff[ax];
            d2_ff[ax]   <= d1_ff[ax];
            m2_ff[ax]   <= MW'(h1_ff[ax]) * MW'(t_a1_ff);
            c3_ff[ax]   <= c2_ff[ax];
            d3_ff[ax]   <= d2_ff[ax];
            h2_ff[ax]   <= COEF_W'((m2_ff[ax] + HALF) >>> FRAC_BITS) + c3_ff[ax];
            d4_ff[ax]   <= d3_ff[ax];
            m3_ff[ax]   <= MW'(h2_ff[ax]) * MW'(t_a2_ff);
            d5_ff[ax]   <= d4_ff[ax];
            h3_ff[ax]   <= COEF_W'((m3_ff[ax] + HALF) >>> FRAC_BITS) + d5_ff[ax];
            out_ff[32*ax +: 32] <= out_in[ax];
         end
      end
   end
endmodule

>>> rtl/core/closed_spline_position_evaluator.sv
// Top level of the closed-loop Catmull-Rom position evaluator.
// Use:
//  - req channel carries one item per handshake. tuser = func: 0 stores a
//    control point at point_index (slots at or beyond MAX_POINTS are dropped),
//    1 evaluates the loop position at elapsed_ms.
//  - rsp channel returns one item (pos_x, pos_y, pos_z, Q16.16, saturated)
//    per evaluate item, in order; write items return nothing.
//  - csr port: index 0 num_points, index 1 period_ms; write only while idle.
// An evaluation passes through 32 stages of time-mod-period, a multiply, one
// divider stage per quotient bit, an index stage, the table read and an
// eight-stage cubic pipeline. Throughput is one evaluate item per cycle while
// rsp_tready is high. A point write waits in the front register until every
// earlier evaluation has read the table, so a write right after evaluations
// holds the request channel until those evaluations reach the table read.
// When the receiver stalls, the whole back pipeline holds; the four-entry
// queue and the front register keep taking items until they fill.
// Reset empties the pipeline and queue and sets num_points 4, period 1000;
// the point table is not cleared and must be written before it is used.
module closed_spline_position_evaluator import csp_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_index[5:0], point_x[37:6], point_y[69:38], point_z[101:70],
   // elapsed_ms[133:102], zero pad [135:134]
   input  logic [135:0] req_tdata,
   // func
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
   output logic [95:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [23:0]  csr_wdata
);
   // evaluations in flight ahead of the table read, with margin
   localparam int INFLIGHT = QDEPTH + 40 + $clog2(MAX_POINTS) + FRAC_BITS;
   localparam int CNT_W    = $clog2(INFLIGHT + 1);

   cfg_type           cfg;
   wr_type            wr;
   logic              q_push, q_pop, q_full, q_empty, rd_take;
   logic [TIME_W-1:0] q_in, q_out;

   csp_front #(.MAX_POINTS(MAX_POINTS), .CNT_W(CNT_W)) u_front (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .csr_we, .csr_index, .csr_wdata,
      .cfg, .wr,
      .q_push, .q_data(q_in), .q_full, .rd_take
   );

   csp_fifo #(.DEPTH(QDEPTH), .W(TIME_W)) u_queue (
      .clock, .reset,
      .push(q_push), .push_data(q_in),
      .pop(q_pop), .pop_data(q_out),
      .full(q_full), .empty(q_empty)
   );

   csp_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset,
      .cfg, .wr,
      .q_empty, .q_data(q_out), .q_pop, .rd_take,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

>>> rtl/core/csp_checker.sv
// Port-level checks of the spline evaluator and their bind.
`include "closed_spline_position_evaluator_defines.svh"

module csp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);
   // a stalled result stays offered
   `CSP_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // a stalled result keeps its data
   `CSP_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // reset empties the output register
   `CSP_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid)
   // no result is offered while the pipeline refills after reset
   `CSP_IMPLY(a_rsp_latency, clock, reset, $past(reset, 2), !rsp_tvalid)
endmodule

bind closed_spline_position_evaluator csp_checker u_csp_checker (.*);

>>> tb/sv/closed_spline_position_evaluator_tb.sv
// Testbench of the closed-loop Catmull-Rom position evaluator.
module closed_spline_position_evaluator_tb;
   import csp_pkg::*;

   localparam int NPTS      = 64;
   localparam int QBITS     = 16;
   localparam int LATENCY   = 80;      // settle wait in drain, longer than the pipeline is deep
   localparam int WD_LIMIT  = 20000;   // cycles with no handshake before giving up

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         req_tuser = FUNC_WRITE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_NUM_POINTS;
   logic [23:0]  csr_wdata = '0;

   closed_spline_position_evaluator #(.MAX_POINTS(NPTS), .FRAC_BITS(QBITS)) dut (.*);

   always #5 clock = ~clock;

   // Predictor state: point table and the registers.
   logic signed [31:0] pt_tab [NPTS][3];
   logic [NUM_W-1:0]   loop_pts;
   logic [PER_W-1:0]   loop_per;

   logic [95:0] pos_queue[$];
   int          mismatches;
   int          idle_cycles;
   bit          hold_off;     // receiver long stall request
   bit          rx_busy;      // receiver pattern enable

   // Rounded Q16 product, floor((v + half) / 2^16); >>> floors on signed values.
   function automatic longint rnd_q(longint v);
      return (v + (64'sd1 <<< (QBITS - 1))) >>> QBITS;
   endfunction

   function automatic logic [31:0] spline_axis(longint p0, longint p1, longint p2,
                                               longint p3, longint t);
      longint a, b, c, h;
      a = -p0 + 3 * p1 - 3 * p2 + p3;
      b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c = -p0 + p2;
      h = rnd_q(a * t) + b;
      h = rnd_q(h * t) + c;
      h = rnd_q(h * t) + 2 * p1;
      h = (h + 1) >>> 1;
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      return h[31:0];
   endfunction

   function automatic logic [95:0] loop_position(logic [31:0] ms);
      longint unsigned n, per, tm, phase, seg, rem, t;
      int              idx [4];
      logic [31:0]     axis [3];
      n = (loop_pts == 0) ? 1 : loop_pts;
      if (n > NPTS) n = NPTS;
      per = (loop_per == 0) ? 1 : loop_per;
      tm = ms % per;
      phase = tm * n;
      seg = phase / per;
      rem = phase % per;
      t = (rem << QBITS) / per;
      idx[0] = int'((seg + n - 1) % n);
      for (int k = 1; k < 4; k++) idx[k] = int'((idx[k-1] + 1) % n);
      for (int a = 0; a < 3; a++)
         axis[a] = spline_axis(pt_tab[idx[0]][a], pt_tab[idx[1]][a],
                               pt_tab[idx[2]][a], pt_tab[idx[3]][a], t);
      return {axis[2], axis[1], axis[0]};
   endfunction

   // Watchdog: counts cycles without any handshake.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WD_LIMIT) begin
         $display("closed_spline_position_evaluator_tb: FAIL");
         $finish;
      end
   end

   // Receiver: stalls on its own pattern, plus a long hold-off when asked.
   always @(posedge clock) begin
      if (reset || hold_off)
         rsp_tready <= 1'b0;
      else if (!rx_busy)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // Result checker: compares each accepted item with the oldest expectation.
   always @(posedge clock) begin
      logic [95:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pos_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want = pos_queue.pop_front();
            for (int a = 0; a < 3; a++)
               if (rsp_tdata[32*a +: 32] !== want[32*a +: 32]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("axis %0d: expected %h got %h", a,
                              want[32*a +: 32], rsp_tdata[32*a +: 32]);
               end
         end
      end
   end

   // Sends one item and updates the predictor once it is accepted.
   task automatic send_item(logic func, logic [5:0] slot, logic [31:0] px,
                            logic [31:0] py, logic [31:0] pz, logic [31:0] ms);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, ms, pz, py, px, slot};
      do @(posedge clock); while (!req_tready);
      if (func == FUNC_WRITE) begin
         pt_tab[slot][0] = px;
         pt_tab[slot][1] = py;
         pt_tab[slot][2] = pz;
      end else begin
         pos_queue.push_back(loop_position(ms));
      end
   endtask

   // Sometimes lowers valid for a random gap right after the last handshake.
   task automatic sender_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pos_queue.size() != 0) @(posedge clock);
      // write items give no result, so let the pipeline settle too
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [23:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NUM_POINTS) loop_pts = val[NUM_W-1:0];
      else                       loop_per = val;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_ms();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 5000);
         1: return 32'hffffffff - $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   // Fill every slot so that any loop size reads only written entries.
   task automatic test_fill_table();
      for (int s = 0; s < NPTS; s++) begin
         send_item(FUNC_WRITE, 6'(s), rand_coord(), rand_coord(), rand_coord(), $urandom());
         sender_gap();
      end
      drain();
   endtask

   // Directed: field extremes, period and count edges, loop wraparound.
   task automatic test_directed();
      send_item(FUNC_WRITE, 0, 32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff);
      send_item(FUNC_WRITE, 1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0);
      send_item(FUNC_WRITE, 2, 32'h7fffffff, 32'h80000000, 32'h00010000, 0);
      send_item(FUNC_WRITE, 63, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
      send_item(FUNC_EVAL, 6'h3f, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
      send_item(FUNC_EVAL, 0, 0, 0, 0, 32'hffffffff);
      send_item(FUNC_EVAL, 0, 0, 0, 0, 999);
      send_item(FUNC_EVAL, 0, 0, 0, 0, 250);
      send_item(FUNC_EVAL, 0, 0, 0, 0, 1000);
      drain();
      // point count zero acts as one, period zero as one
      write_csr(CSR_NUM_POINTS, 0);
      write_csr(CSR_PERIOD, 0);
      send_item(FUNC_EVAL, 0, 0, 0, 0, 12345);
      drain();
      // point count beyond the table saturates
      write_csr(CSR_NUM_POINTS, 24'h7f);
      write_csr(CSR_PERIOD, 24'hffffff);
      send_item(FUNC_EVAL, 0, 0, 0, 0, 32'hffffffff);
      send_item(FUNC_EVAL, 0, 0, 0, 0, 32'h00fffffe);
      drain();
      write_csr(CSR_NUM_POINTS, 64);
      write_csr(CSR_PERIOD, 1);
      send_item(FUNC_EVAL, 0, 0, 0, 0, 7);
      drain();
   endtask

   // Random mix of writes and evaluations over several register settings.
   task automatic test_random(int n_items, bit stall_rx);
      logic [23:0] per_opts [5] = '{24'd1, 24'd1000, 24'd7, 24'hffffff, 24'd0};
      rx_busy = stall_rx;
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(CSR_NUM_POINTS,
                   24'((phase == 0) ? 1 : (phase == 1) ? 64 : $urandom_range(0, 127)));
         write_csr(CSR_PERIOD,
                   (phase < 5) ? per_opts[phase] : 24'($urandom_range(1, 24'hffffff)));
         for (int i = 0; i < n_items / 6; i++) begin
            if ($urandom_range(0, 4) == 0)
               send_item(FUNC_WRITE, 6'($urandom_range(0, 63)), rand_coord(), rand_coord(),
                         rand_coord(), $urandom());
            else
               send_item(FUNC_EVAL, 6'($urandom()), $urandom(), $urandom(), $urandom(),
                         rand_ms());
            sender_gap();
         end
         drain();
      end
   endtask

   // Receiver holds off while the sender keeps offering; input must back up.
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 120; i++)
            send_item(FUNC_EVAL, 0, 0, 0, 0, rand_ms());
      join
      drain();
   endtask

   initial begin
      mismatches = 0;
      hold_off = 1'b0;
      rx_busy = 1'b0;
      loop_pts = 4;
      loop_per = 1000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_table();
      test_directed();
      test_random(600, 1'b0);
      test_random(900, 1'b1);
      test_backpressure();
      if (mismatches == 0 && pos_queue.size() == 0)
         $display("closed_spline_position_evaluator_tb: PASS");
      else
         $display("closed_spline_position_evaluator_tb: FAIL");
      $finish;
   end
endmodule

>>> closed_spline_position_evaluator.f
+incdir+rtl/core
rtl/core/csp_pkg.sv
rtl/core/csp_fifo.sv
rtl/core/csp_front.sv
rtl/core/csp_back.sv
rtl/core/closed_spline_position_evaluator.sv
rtl/core/csp_checker.sv
tb/sv/closed_spline_position_evaluator_tb.sv
